[src/ilp_pkg.sv]
// Shared constants, control structs and a table-building function for the
// ink level pipeline. No dependencies.
`default_nettype none

package ilp_pkg;

  localparam int CH_W       = 8;
  localparam int IDX_W      = 8;
  localparam int TAB_DEPTH  = 1 << IDX_W;
  localparam int WEIGHT_W   = 16;
  localparam int LUM_STAGES = 3;

  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

  localparam logic [31:0] LIN_DEN = 32'd255;
  localparam logic [31:0] THR_DEN = 32'd510;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lum_en_t;

  typedef struct packed {
    logic a;
    logic b;
  } step_en_t;

  // round(2^f * (n/d)^2.2), exact bisection on wide integers; elaboration only
  function automatic logic [31:0] fit_pow(input logic [31:0] n, input logic [31:0] d,
                                          input int f);
    logic [255:0] rhs;
    logic [255:0] lhs;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  mid;
    rhs = 256'd1;
    for (int i = 0; i < 11; i++) rhs = rhs * 256'(n);
    rhs = rhs << (5 * f + 5);
    lo = 32'd0;
    hi = 32'd1 << f;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 32'd1) >> 1);
      lhs = 256'd1;
      for (int i = 0; i < 5; i++) lhs = lhs * 256'({mid[30:0], 1'b0} - 32'd1);
      for (int i = 0; i < 11; i++) lhs = lhs * 256'(d);
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 32'd1;
      end
    end
    return lo;
  endfunction

endpackage

`default_nettype wire

[src/ilp_lum.sv]
// Three-stage luminance unit: gamma table lookup, weight multiply, sum.
// Depends on ilp_pkg.
`default_nettype none

module ilp_lum
  import ilp_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  lum_en_t                           en,
  input  logic [CH_W-1:0]                   red,
  input  logic [CH_W-1:0]                   green,
  input  logic [CH_W-1:0]                   blue,
  output logic [FRACTION_BITS+WEIGHT_W:0]   lum
);

  localparam int LW   = FRACTION_BITS + 1;
  localparam int PRW  = LW + WEIGHT_W;
  localparam int LUMW = FRACTION_BITS + WEIGHT_W + 1;

  typedef logic [TAB_DEPTH-1:0][LW-1:0] tab_t;

  function automatic tab_t build_lin();
    tab_t t;
    for (int i = 0; i < TAB_DEPTH; i++) t[i] = LW'(fit_pow(32'(i), LIN_DEN, FRACTION_BITS));
    return t;
  endfunction

  localparam tab_t LIN_TAB = build_lin();

  logic [LW-1:0]   lin_r_r, lin_g_r, lin_b_r;
  logic [LW-1:0]   lin_r_nxt, lin_g_nxt, lin_b_nxt;
  logic [PRW-1:0]  p_r_r, p_g_r, p_b_r;
  logic [PRW-1:0]  p_r_nxt, p_g_nxt, p_b_nxt;
  logic [LUMW-1:0] lum_r, lum_nxt;

  always_comb begin
    lin_r_nxt = LIN_TAB[red];
    lin_g_nxt = LIN_TAB[green];
    lin_b_nxt = LIN_TAB[blue];
    p_r_nxt   = PRW'(lin_r_r) * PRW'(W_RED);
    p_g_nxt   = PRW'(lin_g_r) * PRW'(W_GREEN);
    p_b_nxt   = PRW'(lin_b_r) * PRW'(W_BLUE);
    lum_nxt   = LUMW'(p_r_r) + LUMW'(p_g_r) + LUMW'(p_b_r);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      lin_r_r <= lin_r_nxt;
      lin_g_r <= lin_g_nxt;
      lin_b_r <= lin_b_nxt;
    end
    if (en.s2) begin
      p_r_r <= p_r_nxt;
      p_g_r <= p_g_nxt;
      p_b_r <= p_b_nxt;
    end
    if (en.s3) begin
      lum_r <= lum_nxt;
    end
  end

  assign lum = lum_r;

endmodule

`default_nettype wire

[src/ilp_step.sv]
// One bit of the threshold search: threshold lookup and split multiply,
// then add and compare. Depends on ilp_pkg.
`default_nettype none

module ilp_step
  import ilp_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int STEP          = 0
) (
  input  logic                              clk,
  input  step_en_t                          en,
  input  logic [IDX_W-1:0]                  cur_i,
  input  logic [FRACTION_BITS+WEIGHT_W:0]   ink_i,
  input  logic [FRACTION_BITS+WEIGHT_W:0]   pap_i,
  output logic [IDX_W-1:0]                  cur_o,
  output logic [FRACTION_BITS+WEIGHT_W:0]   ink_o,
  output logic [FRACTION_BITS+WEIGHT_W:0]   pap_o
);

  localparam int LW     = FRACTION_BITS + 1;
  localparam int LUMW   = FRACTION_BITS + WEIGHT_W + 1;
  localparam int HALF   = LUMW / 2;
  localparam int HIW    = LUMW - HALF;
  localparam int PW     = LW + LUMW;
  localparam int BITPOS = IDX_W - 1 - STEP;
  localparam logic [IDX_W-1:0] STEP_BIT = IDX_W'(1) << BITPOS;

  typedef logic [TAB_DEPTH-1:0][LW-1:0] tab_t;

  function automatic tab_t build_thr();
    tab_t t;
    t[0] = '0;
    for (int i = 1; i < TAB_DEPTH; i++) begin
      t[i] = LW'(fit_pow(32'(2 * i - 1), THR_DEN, FRACTION_BITS));
    end
    return t;
  endfunction

  localparam tab_t THR_TAB = build_thr();

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LW-1:0]     thr;
  logic [LW+HALF-1:0] pl_r, pl_nxt;
  logic [LW+HIW-1:0] ph_r, ph_nxt;
  logic [LUMW-1:0]   ink_a_r, pap_a_r;
  logic [PW-1:0]     prod, lim;
  logic              pass;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [LUMW-1:0]   ink_b_r, pap_b_r;

  always_comb begin
    idx_nxt = cur_i | STEP_BIT;
    thr     = THR_TAB[idx_nxt];
    pl_nxt  = (LW+HALF)'(thr) * (LW+HALF)'(pap_i[HALF-1:0]);
    ph_nxt  = (LW+HIW)'(thr) * (LW+HIW)'(pap_i[LUMW-1:HALF]);
  end

  // threshold * paper <= ink * 2^F keeps this bit set
  always_comb begin
    prod    = {ph_r, {HALF{1'b0}}} + PW'(pl_r);
    lim     = PW'({ink_a_r, {FRACTION_BITS{1'b0}}});
    pass    = (prod <= lim);
    cur_nxt = pass ? idx_r : (idx_r & ~STEP_BIT);
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      idx_r   <= idx_nxt;
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      ink_a_r <= ink_i;
      pap_a_r <= pap_i;
    end
    if (en.b) begin
      cur_r   <= cur_nxt;
      ink_b_r <= ink_a_r;
      pap_b_r <= pap_a_r;
    end
  end

  assign cur_o = cur_r;
  assign ink_o = ink_b_r;
  assign pap_o = pap_b_r;

endmodule

`default_nettype wire

[src/ink_level_from_paper.sv]
// Ink level of one pixel against its paper pixel: both RGB pixels are
// linearized and weighted into luminance, then an eight-step binary search
// over a gamma threshold table finds the 8-bit level. One pixel per clock
// while the output does not stall; an input transfer passes through three
// luminance stages, two stages per search step (lookup and split multiply,
// then add and compare) and the output register before output valid. Every
// stage holds its item under backpressure and empty stages fill while the
// output stalls. Depends on ilp_pkg, ilp_lum and ilp_step.
`default_nettype none

module ink_level_from_paper
  import ilp_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // ink_red, ink_green, ink_blue, paper_red, paper_green, paper_blue
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // ink_level
  output logic [7:0]  out_tdata
);

  localparam int LUMW = FRACTION_BITS + WEIGHT_W + 1;
  localparam int NST  = LUM_STAGES + 2 * IDX_W;

  logic [NST:0]     en;
  logic [NST-1:0]   v_r, v_nxt, v_prev;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_level_r, out_level_nxt;

  logic [LUMW-1:0]  ink_c [IDX_W+1];
  logic [LUMW-1:0]  pap_c [IDX_W+1];
  logic [IDX_W-1:0] cur_c [IDX_W+1];
  lum_en_t          lum_en;

  assign en[NST] = !out_valid_r || out_tready;

  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  assign in_tready = en[0];
  assign v_prev    = {v_r[NST-2:0], in_tvalid};
  assign lum_en    = '{s1: en[0], s2: en[1], s3: en[2]};

  ilp_lum #(.FRACTION_BITS(FRACTION_BITS)) u_ink_lum (
    .clk   (clk),
    .en    (lum_en),
    .red   (in_tdata[7:0]),
    .green (in_tdata[15:8]),
    .blue  (in_tdata[23:16]),
    .lum   (ink_c[0])
  );

  ilp_lum #(.FRACTION_BITS(FRACTION_BITS)) u_pap_lum (
    .clk   (clk),
    .en    (lum_en),
    .red   (in_tdata[31:24]),
    .green (in_tdata[39:32]),
    .blue  (in_tdata[47:40]),
    .lum   (pap_c[0])
  );

  assign cur_c[0] = '0;

  for (genvar j = 0; j < IDX_W; j++) begin : g_step
    step_en_t step_en;
    assign step_en = '{a: en[LUM_STAGES+2*j], b: en[LUM_STAGES+2*j+1]};
    ilp_step #(.FRACTION_BITS(FRACTION_BITS), .STEP(j)) u_step (
      .clk   (clk),
      .en    (step_en),
      .cur_i (cur_c[j]),
      .ink_i (ink_c[j]),
      .pap_i (pap_c[j]),
      .cur_o (cur_c[j+1]),
      .ink_o (ink_c[j+1]),
      .pap_o (pap_c[j+1])
    );
  end

  always_comb begin
    for (int i = 0; i < NST; i++) v_nxt[i] = en[i] ? v_prev[i] : v_r[i];
    out_valid_nxt = en[NST] ? v_r[NST-1] : out_valid_r;
    out_level_nxt = en[NST] ? cur_c[IDX_W] : out_level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_level_r <= out_level_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_level_r;

  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted transfer did not enter the first stage");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && en[NST] |=> out_valid_r)
    else $error("item from last stage lost before output register");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && out_valid_r && !out_tready)
    else $error("input stalled while pipeline has room");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_level_r))
    else $error("stalled result changed or dropped");

endmodule

`default_nettype wire
